// ----- src/kbmn_pkg.sv -----
`default_nettype none

package kbmn_pkg;

	localparam int KEYS_IN_W   = 17;
	localparam int OCT_W       = 4;
	localparam int VEL_W       = 7;
	localparam int CHAN_W      = 4;
	localparam int NOTE_W      = 7;
	localparam int NOTE_SUM_W  = 8;
	localparam int KEY_IDX_W   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam logic [OCT_W-1:0]      OCTAVE_RESET   = OCT_W'(3);
	localparam logic [OCT_W-1:0]      OCTAVE_MAX     = OCT_W'(8);
	localparam logic [VEL_W-1:0]      VELOCITY_RESET = VEL_W'(100);
	localparam logic [VEL_W-1:0]      VELOCITY_MIN   = VEL_W'(1);
	localparam logic [CHAN_W-1:0]     CHANNEL_RESET  = CHAN_W'(0);
	localparam logic [NOTE_SUM_W-1:0] SEMITONES      = NOTE_SUM_W'(12);
	localparam logic [NOTE_SUM_W-1:0] NOTE_MAX       = NOTE_SUM_W'(127);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OCTAVE   = 2'd0,
		CFG_VELOCITY = 2'd1,
		CFG_CHANNEL  = 2'd2
	} cfg_idx_t;

	// register values as used by the datapath, already clamped
	typedef struct packed {
		logic [OCT_W-1:0]  octave;
		logic [VEL_W-1:0]  velocity;
		logic [CHAN_W-1:0] channel;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic pending_empty;
		logic cur_changed;
		logic slot_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- src/kbmn_cfg.sv -----
`default_nettype none

module kbmn_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [kbmn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kbmn_pkg::CFG_DATA_W-1:0]  cfg_data,
	output kbmn_pkg::cfg_t                        cfg
);
	import kbmn_pkg::*;

	logic [OCT_W-1:0]  octave_q;
	logic [VEL_W-1:0]  velocity_q;
	logic [CHAN_W-1:0] channel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q   <= OCTAVE_RESET;
			velocity_q <= VELOCITY_RESET;
			channel_q  <= CHANNEL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OCTAVE:   octave_q   <= cfg_data[OCT_W-1:0];
				CFG_VELOCITY: velocity_q <= cfg_data[VEL_W-1:0];
				CFG_CHANNEL:  channel_q  <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range octave acts as the top octave, zero velocity as one
	assign cfg.octave   = (octave_q > OCTAVE_MAX) ? OCTAVE_MAX : octave_q;
	assign cfg.velocity = (velocity_q == '0) ? VELOCITY_MIN : velocity_q;
	assign cfg.channel  = channel_q;

endmodule

`default_nettype wire

// ----- src/kbmn_ctrl.sv -----
`default_nettype none

module kbmn_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire kbmn_pkg::dp_stat_t stat,
	output kbmn_pkg::dp_cmd_t       cmd
);
	import kbmn_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SCAN;
				ST_SCAN: if (stat.pending_empty) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				// a changed key waits here until the output slot frees up
				if (!stat.pending_empty) begin
					if (stat.cur_changed) begin
						cmd.emit    = stat.slot_free;
						cmd.advance = stat.slot_free;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/kbmn_dp.sv -----
`default_nettype none

module kbmn_dp #(
	parameter int NUM_KEYS = 17
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kbmn_pkg::cfg_t                    cfg,
	input  wire kbmn_pkg::dp_cmd_t                 cmd,
	output kbmn_pkg::dp_stat_t                     stat,
	input  wire logic [kbmn_pkg::KEYS_IN_W-1:0]    pressed_keys,
	input  wire logic                              shift_held,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [kbmn_pkg::OUT_TDATA_W-1:0]       out_data,
	output logic                                   out_note_on,
	output logic                                   out_last
);
	import kbmn_pkg::*;

	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [NUM_KEYS-1:0] scan_keys;
	logic [NUM_KEYS-1:0] held_q;
	logic [NUM_KEYS-1:0] pending_q;
	logic [NUM_KEYS-1:0] pending_rest;
	logic [KEY_W-1:0]    key_q;
	logic                shift_q;

	logic [NOTE_W-1:0]   note_mem [NUM_KEYS];
	logic [CHAN_W-1:0]   chan_mem [NUM_KEYS];

	logic [NOTE_SUM_W-1:0] note_sum;
	logic [NOTE_W-1:0]     new_note;
	logic                  cur_on;

	logic                  out_valid_q;
	logic                  out_on_q;
	logic                  out_last_q;
	logic [CHAN_W-1:0]     out_chan_q;
	logic [NOTE_W-1:0]     out_note_q;
	logic [VEL_W-1:0]      out_vel_q;
	logic [KEY_IDX_W-1:0]  out_key_q;

	// keys beyond the keyboard are dropped, missing ones read as released
	if (NUM_KEYS <= KEYS_IN_W) begin : g_trim
		assign scan_keys = pressed_keys[NUM_KEYS-1:0];
	end else begin : g_pad
		assign scan_keys = {{(NUM_KEYS-KEYS_IN_W){1'b0}}, pressed_keys};
	end

	assign cur_on       = held_q[key_q];
	assign pending_rest = pending_q & ~(NUM_KEYS'(1) << key_q);

	assign note_sum = NOTE_SUM_W'(key_q) + NOTE_SUM_W'(cfg.octave) * SEMITONES
		+ (shift_q ? SEMITONES : '0);
	assign new_note = (note_sum > NOTE_MAX) ? NOTE_MAX[NOTE_W-1:0] : note_sum[NOTE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			pending_q <= '0;
			key_q     <= '0;
		end else if (cmd.load) begin
			held_q    <= scan_keys;
			pending_q <= scan_keys ^ held_q;
			key_q     <= '0;
		end else if (cmd.advance) begin
			pending_q <= pending_rest;
			key_q     <= key_q + KEY_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) shift_q <= shift_held;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && cur_on) begin
			note_mem[key_q] <= new_note;
			chan_mem[key_q] <= cfg.channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// note-off takes the note and channel stored at its note-on
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_on_q   <= cur_on;
			out_last_q <= (pending_rest == '0);
			out_chan_q <= cur_on ? cfg.channel : chan_mem[key_q];
			out_note_q <= cur_on ? new_note : note_mem[key_q];
			out_vel_q  <= cur_on ? cfg.velocity : '0;
			out_key_q  <= KEY_IDX_W'(key_q);
		end
	end

	assign stat.pending_empty = (pending_q == '0);
	assign stat.cur_changed   = pending_q[key_q];
	assign stat.slot_free     = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_note_on = out_on_q;
	assign out_last    = out_last_q;
	assign out_data    = {1'b0, out_key_q, out_vel_q, out_note_q, out_chan_q};

endmodule

`default_nettype wire

// ----- src/key_bitmap_to_midi_notes_core.sv -----
// Turns key scans into note events. Each beat on s_axis is one scan of the
// key bitmap plus the shift flag; every key that changed since the previous
// scan gives one beat on m_axis, in ascending key order, note-on for a new
// press and note-off (stored note and channel, velocity zero) for a release,
// with tlast on the final event of the scan. A scan with no change gives no
// beat. A key counter steps through the keyboard one key per cycle past the
// note store, up to the highest changed key, holding on a changed key while
// m_axis stalls a pending event. The next scan is taken as soon as the
// counter is done, even while the last event still waits in the output
// register. Register writes are taken in any cycle and are meant to be made
// between scans.
`default_nettype none

module key_bitmap_to_midi_notes_core #(
	parameter int NUM_KEYS = 17
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kbmn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kbmn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// pressed_keys [16:0], zero [23:17]
	input  wire logic [kbmn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// shift_held
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// event_channel [3:0], note_number [10:4], event_velocity [17:11],
	// key_index [22:18], zero [23]
	output logic [kbmn_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// is_note_on
	output logic                                     m_axis_tuser,
	// last_event
	output logic                                     m_axis_tlast
);
	import kbmn_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	kbmn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kbmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kbmn_dp #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.pressed_keys (s_axis_tdata[KEYS_IN_W-1:0]),
		.shift_held   (s_axis_tuser),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.out_note_on  (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

	// one scan at a time: the counter is busy right after a scan is taken
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("scan taken while previous scan still in progress");

	a_off_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[17:11] == '0)
		else $error("note-off with nonzero velocity");

	a_on_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[17:11] != '0)
		else $error("note-on with zero velocity");

	a_emit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !s_axis_tready && stat.cur_changed && stat.slot_free)
		else $error("event emitted outside a scan or into a full slot");

endmodule

`default_nettype wire
